/* hw/rtl/bpq_pkg.sv */
// Shared types and constants for the buffer pool queue manager.
// No dependencies.
`default_nettype none

package bpq_pkg;

  localparam int NUM_BLOCKS = 128;
  localparam int BLK_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  typedef logic [BLK_W-1:0] blk_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    CMD_ALLOC = 3'd0,
    CMD_QUEUE = 3'd1,
    CMD_POP   = 3'd2,
    CMD_FREE  = 3'd3,
    CMD_UNPOP = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NOBLK = 2'd2
  } status_t;

  // one link memory update per beat: a data write and a zero mark
  typedef struct packed {
    logic mem_we;
    blk_t mem_addr;
    blk_t mem_data;
    logic zero_we;
    blk_t zero_addr;
  } link_wr_t;

  typedef struct packed {
    blk_t    block_out;
    status_t status;
    logic    overflow;
    cnt_t    free_length;
    cnt_t    queue_length;
    cnt_t    free_length_min;
    cnt_t    free_length_max;
    cnt_t    queue_length_min;
    cnt_t    queue_length_max;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/bpq_link_store.sv */
// Link memory with registered read, plus per-entry written and zero flags.
// Depends on bpq_pkg.
`default_nettype none

module bpq_link_store import bpq_pkg::*; (
  input  wire      clk,
  input  wire      rst,
  input  wire      rd_en,
  input  blk_t     rd_addr,
  input  link_wr_t wr,
  output blk_t     link
);

  blk_t                  mem [NUM_BLOCKS];
  blk_t                  rdata;
  blk_t                  ra;
  logic [NUM_BLOCKS-1:0] written;
  logic [NUM_BLOCKS-1:0] zero;

  function automatic blk_t link_init(blk_t i);
    cnt_t nx;
    nx = {1'b0, i} + CNT_W'(1);
    link_init = (nx < CNT_W'(NUM_BLOCKS)) ? nx[BLK_W-1:0] : '0;
  endfunction

  always_ff @(posedge clk) begin
    if (wr.mem_we) begin
      mem[wr.mem_addr] <= wr.mem_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
      ra    <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      zero    <= '0;
    end else begin
      if (wr.mem_we) begin
        written[wr.mem_addr] <= 1'b1;
        zero[wr.mem_addr]    <= 1'b0;
      end
      // zero mark follows the data write
      if (wr.zero_we) begin
        zero[wr.zero_addr] <= 1'b1;
      end
    end
  end

  assign link = zero[ra] ? '0 : (written[ra] ? rdata : link_init(ra));

endmodule

`default_nettype wire

/* hw/rtl/bpq_cmd_unit.sv */
// List state (heads, tails, counts, min/max, overflow) and command decode.
// Depends on bpq_pkg.
`default_nettype none

module bpq_cmd_unit import bpq_pkg::*; (
  input  wire           clk,
  input  wire           rst,
  input  wire           issue,
  input  wire     [2:0] cmd,
  input  wire     [BLK_W-1:0] block_in,
  input  wire           commit,
  input  blk_t          link,
  output blk_t          rd_addr,
  output link_wr_t      wr,
  output result_t       res_next
);

  logic [2:0] cmd_q;
  blk_t       blk_q;

  blk_t fhead, ftail, qhead, qtail;
  cnt_t fcnt, fmin, fmax, qcnt, qmin, qmax;
  logic ovf;

  blk_t    fhead_next, ftail_next, qhead_next, qtail_next;
  cnt_t    fcnt_next, fmin_next, fmax_next, qcnt_next, qmin_next, qmax_next;
  logic    ovf_next;
  blk_t    bout;
  status_t st;
  logic    blk_ok;

  always_comb begin
    priority if (cmd == 3'(CMD_ALLOC) && fcnt != '0) begin
      rd_addr = fhead;
    end else if (cmd == 3'(CMD_ALLOC) || cmd == 3'(CMD_POP)) begin
      rd_addr = qhead;
    end else begin
      rd_addr = fhead;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cmd_q <= cmd;
      blk_q <= block_in;
    end
  end

  always_comb begin
    fhead_next = fhead;
    ftail_next = ftail;
    fcnt_next  = fcnt;
    qhead_next = qhead;
    qtail_next = qtail;
    qcnt_next  = qcnt;
    ovf_next   = ovf;
    bout       = '0;
    st         = ST_OK;
    wr         = '0;
    blk_ok     = {1'b0, blk_q} < CNT_W'(NUM_BLOCKS);
    unique case (cmd_t'(cmd_q))
      CMD_ALLOC: begin
        if (fcnt != '0) begin
          bout         = fhead;
          fhead_next   = link;
          fcnt_next    = fcnt - CNT_W'(1);
          wr.zero_we   = 1'b1;
          wr.zero_addr = fhead;
        end else if (qcnt != '0) begin
          bout         = qhead;
          qhead_next   = link;
          qcnt_next    = qcnt - CNT_W'(1);
          wr.zero_we   = 1'b1;
          wr.zero_addr = qhead;
          ovf_next     = 1'b1;
        end else begin
          st = ST_NOBLK;
        end
      end
      CMD_POP: begin
        if (qcnt != '0) begin
          bout         = qhead;
          qhead_next   = link;
          qcnt_next    = qcnt - CNT_W'(1);
          wr.zero_we   = 1'b1;
          wr.zero_addr = qhead;
        end else begin
          st = ST_EMPTY;
        end
      end
      CMD_QUEUE: begin
        if (blk_ok && qcnt < CNT_W'(NUM_BLOCKS)) begin
          if (qcnt == '0) begin
            qhead_next = blk_q;
          end else begin
            wr.mem_we   = 1'b1;
            wr.mem_addr = qtail;
            wr.mem_data = blk_q;
          end
          qtail_next   = blk_q;
          qcnt_next    = qcnt + CNT_W'(1);
          wr.zero_we   = 1'b1;
          wr.zero_addr = blk_q;
        end
      end
      CMD_FREE: begin
        if (blk_ok && fcnt < CNT_W'(NUM_BLOCKS)) begin
          if (fcnt == '0) begin
            fhead_next = blk_q;
          end else begin
            wr.mem_we   = 1'b1;
            wr.mem_addr = ftail;
            wr.mem_data = blk_q;
          end
          ftail_next   = blk_q;
          fcnt_next    = fcnt + CNT_W'(1);
          wr.zero_we   = 1'b1;
          wr.zero_addr = blk_q;
        end
      end
      CMD_UNPOP: begin
        if (blk_ok && fcnt < CNT_W'(NUM_BLOCKS)) begin
          if (fcnt == '0) begin
            ftail_next   = blk_q;
            wr.zero_we   = 1'b1;
            wr.zero_addr = blk_q;
          end else begin
            wr.mem_we   = 1'b1;
            wr.mem_addr = blk_q;
            wr.mem_data = fhead;
          end
          fhead_next = blk_q;
          fcnt_next  = fcnt + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    fmin_next = (fcnt_next < fmin) ? fcnt_next : fmin;
    fmax_next = (fcnt_next > fmax) ? fcnt_next : fmax;
    qmin_next = (qcnt_next < qmin) ? qcnt_next : qmin;
    qmax_next = (qcnt_next > qmax) ? qcnt_next : qmax;
    if (!commit) begin
      wr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fhead <= '0;
      ftail <= BLK_W'(NUM_BLOCKS - 1);
      fcnt  <= CNT_W'(NUM_BLOCKS);
      fmin  <= CNT_W'(NUM_BLOCKS);
      fmax  <= CNT_W'(NUM_BLOCKS);
      qhead <= '0;
      qtail <= '0;
      qcnt  <= '0;
      qmin  <= '0;
      qmax  <= '0;
      ovf   <= 1'b0;
    end else if (commit) begin
      fhead <= fhead_next;
      ftail <= ftail_next;
      fcnt  <= fcnt_next;
      fmin  <= fmin_next;
      fmax  <= fmax_next;
      qhead <= qhead_next;
      qtail <= qtail_next;
      qcnt  <= qcnt_next;
      qmin  <= qmin_next;
      qmax  <= qmax_next;
      ovf   <= ovf_next;
    end
  end

  assign res_next = '{
    block_out:        bout,
    status:           st,
    overflow:         ovf_next,
    free_length:      fcnt_next,
    queue_length:     qcnt_next,
    free_length_min:  fmin_next,
    free_length_max:  fmax_next,
    queue_length_min: qmin_next,
    queue_length_max: qmax_next
  };

endmodule

`default_nettype wire

/* hw/rtl/buffer_pool_queue_manager_core.sv */
// Buffer pool queue manager top level: handshakes, command stage, result register.
// The result register loads when the command stage commits; an unread result holds off the commit.
// A new command is not taken until the previous one commits; the link memory read is registered.
// The output register lets a new command in while a result waits.
// Reset: synchronous; link memory contents are not swept, per-entry flags give reset links.
// Depends on bpq_pkg, bpq_link_store, bpq_cmd_unit.
`default_nettype none

module buffer_pool_queue_manager_core import bpq_pkg::*; (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire  [2:0]       cmd,
  input  wire  [BLK_W-1:0] block_in,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [BLK_W-1:0] block_out,
  output logic [1:0]       status,
  output logic             overflow,
  output logic [CNT_W-1:0] free_length,
  output logic [CNT_W-1:0] queue_length,
  output logic [CNT_W-1:0] free_length_min,
  output logic [CNT_W-1:0] free_length_max,
  output logic [CNT_W-1:0] queue_length_min,
  output logic [CNT_W-1:0] queue_length_max
);

  logic     busy;
  logic     accept;
  logic     commit;
  blk_t     rd_addr;
  blk_t     link;
  link_wr_t wr;
  result_t  res_next;
  result_t  res;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign commit   = busy && (!out_valid || out_ready);

  bpq_link_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .wr      (wr),
    .link    (link)
  );

  bpq_cmd_unit u_cmd (
    .clk      (clk),
    .rst      (rst),
    .issue    (accept),
    .cmd      (cmd),
    .block_in (block_in),
    .commit   (commit),
    .link     (link),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (commit) begin
        busy <= 1'b0;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res <= res_next;
    end
  end

  assign block_out        = res.block_out;
  assign status           = res.status;
  assign overflow         = res.overflow;
  assign free_length      = res.free_length;
  assign queue_length     = res.queue_length;
  assign free_length_min  = res.free_length_min;
  assign free_length_max  = res.free_length_max;
  assign queue_length_min = res.queue_length_min;
  assign queue_length_max = res.queue_length_max;

endmodule

`default_nettype wire
